// ----- rtl/crp_pkg.sv -----
// circle_rect_pushout package: widths, step counts and the side-band record
// used by circle_rect_pushout_top; no dependencies
package crp_pkg;

    localparam int CoordW    = 32;
    localparam int RadW      = 31;
    localparam int MagW      = 33;
    localparam int SqW       = 64;
    localparam int RootW     = 32;
    localparam int SqrtSteps = 32;
    localparam int ProdW     = 62;
    localparam int DivSteps  = 31;

    typedef struct packed {
        logic              hit;
        logic              zero;
        logic              neg_x;
        logic              neg_z;
        logic [RadW-1:0]   r;
        logic [RadW-1:0]   mx;
        logic [RadW-1:0]   mz;
    } side_t;

endpackage

// ----- rtl/circle_rect_pushout_top.sv -----
// circle_rect_pushout_top: circle against wall rectangle push-out, fully pipelined
// depends on crp_pkg
//
// input channel: in_valid / in_stall carries one word of corners, centre and radius
// output channel: out_valid / out_stall carries hit, push_x, push_z
// one word is accepted per cycle when the output is not stalled
// stages from acceptance to out_valid: input register, clamp,
//   squares, sum and compare, 32 square root steps, product stage,
//   divider load, 31 division steps, output register
// throughput: one word per cycle while the output is not stalled; the figure is set
//   by the one-step-per-stage square root and the two one-bit-per-stage dividers
// reset: all valid bits clear, the pipe is empty, out_valid is low
// stall: while out_valid is high and out_stall is high the whole pipe holds,
//   in_stall is raised and no word is lost or repeated
// results: hit and a push of depth times unit direction to the closest point,
//   zero direction gives +z with the radius, a miss gives zero push
// push components are truncated toward zero
module circle_rect_pushout_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [crp_pkg::CoordW-1:0] corner_a_x,
    input  logic signed [crp_pkg::CoordW-1:0] corner_a_z,
    input  logic signed [crp_pkg::CoordW-1:0] corner_b_x,
    input  logic signed [crp_pkg::CoordW-1:0] corner_b_z,
    input  logic signed [crp_pkg::CoordW-1:0] center_x,
    input  logic signed [crp_pkg::CoordW-1:0] center_z,
    input  logic        [crp_pkg::RadW-1:0]   radius,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              hit,
    output logic signed [crp_pkg::CoordW-1:0] push_x,
    output logic signed [crp_pkg::CoordW-1:0] push_z
);
    import crp_pkg::*;

    logic en;

    // stage 0: input register
    logic                     v0_reg;
    logic signed [CoordW-1:0] ax_reg, az_reg, bx_reg, bz_reg, cx_reg, cz_reg;
    logic        [RadW-1:0]   r0_reg;

    // stage 1: clamp
    logic                     v1_reg;
    logic signed [MagW-1:0]   dx_reg, dz_reg;
    logic        [RadW-1:0]   r1_reg;
    logic                     far_reg;

    // stage 2: squares
    logic                     v2_reg;
    logic        [SqW-1:0]    sqx_reg, sqz_reg, rr_reg;
    logic        [RadW-1:0]   r2_reg, mx2_reg, mz2_reg;
    logic                     far2_reg, nx2_reg, nz2_reg;

    // square root pipe
    logic                     sv_reg   [SqrtSteps+1];
    side_t                    ss_reg   [SqrtSteps+1];
    logic        [MagW:0]     srem_reg [SqrtSteps+1];
    logic        [RootW-1:0]  sroot_reg[SqrtSteps+1];
    logic        [SqW-1:0]    sn_reg   [SqrtSteps+1];

    // product stage
    logic                     pv_reg;
    side_t                    ps_reg;
    logic        [ProdW-1:0]  px_reg, pz_reg;
    logic        [RootW-1:0]  pd_reg;

    // divider pipe
    logic                     dv_reg  [DivSteps+1];
    side_t                    ds_reg  [DivSteps+1];
    logic        [RootW-1:0]  dd_reg  [DivSteps+1];
    logic        [RootW-1:0]  xrem_reg[DivSteps+1];
    logic        [RootW-1:0]  zrem_reg[DivSteps+1];
    logic        [ProdW-1:0]  xn_reg  [DivSteps+1];
    logic        [ProdW-1:0]  zn_reg  [DivSteps+1];
    logic        [RadW-1:0]   xq_reg  [DivSteps+1];
    logic        [RadW-1:0]   zq_reg  [DivSteps+1];

    logic                     ov_reg, hit_reg;
    logic signed [CoordW-1:0] px_out_reg, pz_out_reg;

    assign en       = !(ov_reg && out_stall);
    assign in_stall = ov_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            pv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            pv_reg <= sv_reg[SqrtSteps];
            ov_reg <= dv_reg[DivSteps];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg <= corner_a_x;
            az_reg <= corner_a_z;
            bx_reg <= corner_b_x;
            bz_reg <= corner_b_z;
            cx_reg <= center_x;
            cz_reg <= center_z;
            r0_reg <= radius;
        end
    end

    // clamp
    logic signed [CoordW-1:0] lox, hix, loz, hiz, clx, clz;
    logic signed [MagW-1:0]   dx_next, dz_next;
    logic        [MagW-1:0]   mx_abs, mz_abs;

    always_comb
    begin
        lox = (ax_reg < bx_reg) ? ax_reg : bx_reg;
        hix = (ax_reg < bx_reg) ? bx_reg : ax_reg;
        loz = (az_reg < bz_reg) ? az_reg : bz_reg;
        hiz = (az_reg < bz_reg) ? bz_reg : az_reg;
        clx = (cx_reg < lox) ? lox : ((cx_reg > hix) ? hix : cx_reg);
        clz = (cz_reg < loz) ? loz : ((cz_reg > hiz) ? hiz : cz_reg);
        dx_next = MagW'(clx) - MagW'(cx_reg);
        dz_next = MagW'(clz) - MagW'(cz_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= dx_next;
            dz_reg <= dz_next;
            r1_reg <= r0_reg;
        end
    end

    always_comb
    begin
        mx_abs = dx_reg[MagW-1] ? MagW'(-dx_reg) : MagW'(dx_reg);
        mz_abs = dz_reg[MagW-1] ? MagW'(-dz_reg) : MagW'(dz_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg  <= SqW'(mx_abs[RadW-1:0]) * SqW'(mx_abs[RadW-1:0]);
            sqz_reg  <= SqW'(mz_abs[RadW-1:0]) * SqW'(mz_abs[RadW-1:0]);
            rr_reg   <= SqW'(r1_reg) * SqW'(r1_reg);
            far2_reg <= (mx_abs > MagW'(r1_reg)) || (mz_abs > MagW'(r1_reg));
            r2_reg   <= r1_reg;
            mx2_reg  <= mx_abs[RadW-1:0];
            mz2_reg  <= mz_abs[RadW-1:0];
            nx2_reg  <= dx_reg[MagW-1];
            nz2_reg  <= dz_reg[MagW-1];
        end
    end

    // sum and compare, feeds square root stage 0
    logic [SqW-1:0] d2;
    side_t          s_in;

    always_comb
    begin
        d2         = sqx_reg + sqz_reg;
        s_in.hit   = !far2_reg && (d2 <= rr_reg);
        s_in.zero  = (d2 == '0);
        s_in.neg_x = nx2_reg;
        s_in.neg_z = nz2_reg;
        s_in.r     = r2_reg;
        s_in.mx    = mx2_reg;
        s_in.mz    = mz2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sv_reg[0] <= 1'b0;
        else if (en)
            sv_reg[0] <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ss_reg[0]    <= s_in;
            srem_reg[0]  <= '0;
            sroot_reg[0] <= '0;
            sn_reg[0]    <= d2;
        end
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < SqrtSteps; k++)
    begin : g_sqrt
        logic [MagW+1:0] t_in, t_sub;
        logic [MagW+2:0] diff;
        logic            ge;

        always_comb
        begin
            t_in  = {srem_reg[k][MagW-1:0], sn_reg[k][SqW-1:SqW-2]};
            t_sub = {1'b0, sroot_reg[k], 2'b01};
            diff  = {1'b0, t_in} - {1'b0, t_sub};
            ge    = !diff[MagW+2];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sv_reg[k+1] <= 1'b0;
            else if (en)
                sv_reg[k+1] <= sv_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ss_reg[k+1]    <= ss_reg[k];
                srem_reg[k+1]  <= ge ? diff[MagW:0] : t_in[MagW:0];
                sroot_reg[k+1] <= {sroot_reg[k][RootW-2:0], ge};
                sn_reg[k+1]    <= {sn_reg[k][SqW-3:0], 2'b00};
            end
        end
    end

    // depth and products
    logic [RadW-1:0] depth;
    assign depth = ss_reg[SqrtSteps].r - sroot_reg[SqrtSteps][RadW-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ps_reg <= ss_reg[SqrtSteps];
            px_reg <= ProdW'(depth) * ProdW'(ss_reg[SqrtSteps].mx);
            pz_reg <= ProdW'(depth) * ProdW'(ss_reg[SqrtSteps].mz);
            pd_reg <= (sroot_reg[SqrtSteps] == '0) ? RootW'(1) : sroot_reg[SqrtSteps];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg[0] <= 1'b0;
        else if (en)
            dv_reg[0] <= pv_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ds_reg[0]   <= ps_reg;
            dd_reg[0]   <= pd_reg;
            xrem_reg[0] <= RootW'(px_reg[ProdW-1:DivSteps]);
            zrem_reg[0] <= RootW'(pz_reg[ProdW-1:DivSteps]);
            xn_reg[0]   <= px_reg;
            zn_reg[0]   <= pz_reg;
            xq_reg[0]   <= '0;
            zq_reg[0]   <= '0;
        end
    end

    // two dividers, one quotient bit per stage
    for (genvar k = 0; k < DivSteps; k++)
    begin : g_div
        logic [RootW:0]   xt, zt;
        logic [RootW+1:0] xd, zd;
        logic             xge, zge;

        always_comb
        begin
            xt  = {xrem_reg[k], xn_reg[k][DivSteps-1-k]};
            zt  = {zrem_reg[k], zn_reg[k][DivSteps-1-k]};
            xd  = {1'b0, xt} - {2'b00, dd_reg[k]};
            zd  = {1'b0, zt} - {2'b00, dd_reg[k]};
            xge = !xd[RootW+1];
            zge = !zd[RootW+1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[k+1] <= 1'b0;
            else if (en)
                dv_reg[k+1] <= dv_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ds_reg[k+1]   <= ds_reg[k];
                dd_reg[k+1]   <= dd_reg[k];
                xn_reg[k+1]   <= xn_reg[k];
                zn_reg[k+1]   <= zn_reg[k];
                xrem_reg[k+1] <= xge ? xd[RootW-1:0] : xt[RootW-1:0];
                zrem_reg[k+1] <= zge ? zd[RootW-1:0] : zt[RootW-1:0];
                xq_reg[k+1]   <= {xq_reg[k][RadW-2:0], xge};
                zq_reg[k+1]   <= {zq_reg[k][RadW-2:0], zge};
            end
        end
    end

    // sign, special cases and output register
    side_t                    fs;
    logic signed [CoordW-1:0] qx, qz, px_next, pz_next;

    always_comb
    begin
        fs = ds_reg[DivSteps];
        qx = fs.neg_x ? -CoordW'(xq_reg[DivSteps]) : CoordW'(xq_reg[DivSteps]);
        qz = fs.neg_z ? -CoordW'(zq_reg[DivSteps]) : CoordW'(zq_reg[DivSteps]);
        if (!fs.hit)
        begin
            px_next = '0;
            pz_next = '0;
        end
        else if (fs.zero)
        begin
            px_next = '0;
            pz_next = CoordW'(fs.r);
        end
        else
        begin
            px_next = qx;
            pz_next = qz;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg    <= fs.hit;
            px_out_reg <= px_next;
            pz_out_reg <= pz_next;
        end
    end

    assign out_valid = ov_reg;
    assign hit       = hit_reg;
    assign push_x    = px_out_reg;
    assign push_z    = pz_out_reg;

endmodule

// ----- rtl/crp_checker.sv -----
// crp_checker: port-level assertions for circle_rect_pushout_top
// depends on crp_pkg; bound to the top level below
module crp_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic                              hit,
    input logic signed [crp_pkg::CoordW-1:0] push_x,
    input logic signed [crp_pkg::CoordW-1:0] push_z
);
    import crp_pkg::*;

    // a miss carries no push
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> push_x == '0 && push_z == '0)
        else $error("miss word with nonzero push");

    // input only held back by a stalled output word
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output stall");

    // stalled input word stays offered
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("stalled input word withdrawn");

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit) && $stable(push_x)
            && $stable(push_z))
        else $error("stalled output word changed");

    // a hit never gives the most negative value on either push axis
    a_hit_sane: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !(push_x == {1'b1, {(CoordW-1){1'b0}}})
            && !(push_z == {1'b1, {(CoordW-1){1'b0}}}))
        else $error("push magnitude out of range");

endmodule

bind circle_rect_pushout_top crp_checker u_crp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit),
    .push_x    (push_x),
    .push_z    (push_z)
);

// ----- tb/tb_circle_rect_pushout_top.sv -----
// testbench for circle_rect_pushout_top: streams wall and circle words through the
// block and checks hit and push against an exact integer predictor; depends on crp_pkg
`timescale 1ns / 1ps

module tb_circle_rect_pushout_top;

    import crp_pkg::*;

    typedef struct {
        logic              hit;
        logic signed [31:0] px;
        logic signed [31:0] pz;
    } push_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [CoordW-1:0]  corner_a_x;
    logic signed [CoordW-1:0]  corner_a_z;
    logic signed [CoordW-1:0]  corner_b_x;
    logic signed [CoordW-1:0]  corner_b_z;
    logic signed [CoordW-1:0]  center_x;
    logic signed [CoordW-1:0]  center_z;
    logic        [RadW-1:0]    radius;
    logic                      out_valid;
    logic                      out_stall;
    logic                      hit;
    logic signed [CoordW-1:0]  push_x;
    logic signed [CoordW-1:0]  push_z;

    push_t       pending_push[$];
    int          err_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct;
    int          recv_idle_pct;
    localparam int CycleLimit = 400000;

    circle_rect_pushout_top dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .corner_a_x(corner_a_x), .corner_a_z(corner_a_z),
        .corner_b_x(corner_b_x), .corner_b_z(corner_b_z),
        .center_x(center_x), .center_z(center_z), .radius(radius),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit(hit), .push_x(push_x), .push_z(push_z)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic longint clamp_axis(longint v, longint a, longint b);
        longint lo;
        longint hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic [63:0] floor_root(logic [63:0] n);
        logic [63:0] root;
        logic [63:0] rem;
        logic [63:0] trial;
        root = '0;
        rem = n;
        for (int i = 31; i >= 0; i--)
        begin
            trial = (root << (i + 1)) + (64'd1 << (2 * i));
            if (rem >= trial)
            begin
                rem = rem - trial;
                root = root | (64'd1 << i);
            end
        end
        return root;
    endfunction

    function automatic logic signed [31:0] push_axis(logic [63:0] depth, longint d,
                                                     logic [63:0] root_d);
        logic [63:0] mag;
        logic [63:0] q;
        mag = (d < 0) ? -d : d;
        q = (depth * mag) / root_d;
        if (d < 0)
            q = -q;
        return q[31:0];
    endfunction

    function automatic push_t predict_push(logic signed [31:0] ax, logic signed [31:0] az,
                                           logic signed [31:0] bx, logic signed [31:0] bz,
                                           logic signed [31:0] cx, logic signed [31:0] cz,
                                           logic [30:0] rad);
        push_t       res;
        longint      dx;
        longint      dz;
        logic [63:0] mx;
        logic [63:0] mz;
        logic [63:0] r;
        logic [63:0] d2;
        logic [63:0] root_d;
        res.hit = 1'b0;
        res.px = 0;
        res.pz = 0;
        r = 64'(rad);
        dx = clamp_axis(longint'(cx), longint'(ax), longint'(bx)) - longint'(cx);
        dz = clamp_axis(longint'(cz), longint'(az), longint'(bz)) - longint'(cz);
        mx = (dx < 0) ? -dx : dx;
        mz = (dz < 0) ? -dz : dz;
        if (mx > r || mz > r)
            return res;
        d2 = mx * mx + mz * mz;
        if (d2 > r * r)
            return res;
        res.hit = 1'b1;
        if (d2 == 0)
        begin
            res.pz = r[31:0];
            return res;
        end
        root_d = floor_root(d2);
        res.px = push_axis(r - root_d, dx, root_d);
        res.pz = push_axis(r - root_d, dz, root_d);
        return res;
    endfunction

    task automatic send_word(logic signed [31:0] ax, logic signed [31:0] az,
                             logic signed [31:0] bx, logic signed [31:0] bz,
                             logic signed [31:0] cx, logic signed [31:0] cz,
                             logic [30:0] rad);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        corner_a_x <= ax;
        corner_a_z <= az;
        corner_b_x <= bx;
        corner_b_z <= bz;
        center_x <= cx;
        center_z <= cz;
        radius <= rad;
        pending_push.push_back(predict_push(ax, az, bx, bz, cx, cz, rad));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain_idle();
        in_valid <= 1'b0;
        while (pending_push.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        logic signed [31:0] mx;
        logic signed [31:0] mn;
        mx = 32'sh7fffffff;
        mn = 32'sh80000000;
        // centre inside, on edge, corners swapped
        send_word(0, 0, 32'sh10000, 32'sh10000, 32'sh8000, 32'sh8000, 31'h10000);
        send_word(32'sh10000, 32'sh10000, 0, 0, 32'sh10000, 0, 31'h4000);
        send_word(0, 0, 32'sh10000, 32'sh10000, 32'sh18000, 32'sh8000, 31'h10000);
        send_word(0, 0, 32'sh10000, 32'sh10000, 32'sh8000, -32'sh8000, 31'h10000);
        send_word(0, 0, 32'sh10000, 32'sh10000, 32'sh20000, 32'sh20000, 31'h18000);
        send_word(0, 0, 32'sh10000, 32'sh10000, 32'sh20000, 32'sh20000, 31'h16a09);
        send_word(0, 0, 32'sh10000, 32'sh10000, 32'sh20000, 32'sh8000, 31'h10000);
        // far axis
        send_word(0, 0, 32'sh10000, 32'sh10000, mx, 0, 31'h7fffffff);
        send_word(mn, mn, mn, mn, mx, mx, 31'h7fffffff);
        send_word(mn, mn, mx, mx, mn, mx, 31'h7fffffff);
        send_word(mn, mn, mx, mx, 0, 0, 31'd0);
        send_word(mx, mx, mx, mx, 0, 0, 31'h7fffffff);
        send_word(mn, 0, mn, 0, -32'sh1, 0, 31'h7fffffff);
        send_word(mx, mx, mx, mx, mx, 0, 31'h7fffffff);
        send_word(0, 0, 0, 0, 1, 1, 31'd1);
        send_word(0, 0, 0, 0, 1, 1, 31'd2);
        send_word(0, 0, 0, 0, -3, 4, 31'd5);
        send_word(0, 0, 0, 0, 3, -4, 31'h7fffffff);
        send_word(0, 0, 0, 0, 32'sh40000000, 32'sh40000000, 31'h7fffffff);
        send_word(mn, mn, mx, mx, mn, mn, 31'd0);
        drain_idle();
    endtask

    task automatic test_random(int count);
        logic signed [31:0] ax;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] bz;
        logic signed [31:0] cx;
        logic signed [31:0] cz;
        logic [30:0]        rad;
        int                 sh;
        for (int i = 0; i < count; i++)
        begin
            sh = $urandom_range(31, 8);
            ax = $signed($urandom) >>> (32 - sh);
            az = $signed($urandom) >>> (32 - sh);
            bx = $signed($urandom) >>> (32 - sh);
            bz = $signed($urandom) >>> (32 - sh);
            cx = $signed($urandom) >>> (31 - sh);
            cz = $signed($urandom) >>> (31 - sh);
            rad = 31'($urandom >> (32 - sh));
            case ($urandom_range(9))
                0:
                begin
                    cx = $urandom;
                    cz = $urandom;
                    rad = 31'($urandom);
                end
                1:
                begin
                    ax = $urandom;
                    bx = $urandom;
                    az = $urandom;
                    bz = $urandom;
                end
                2: rad = 31'(32'h7fffffff - $urandom_range(3));
                default: ;
            endcase
            send_word(ax, az, bx, bz, cx, cz, rad);
        end
        drain_idle();
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_push.size() == 0)
            begin
                $display("%0t unexpected word hit=%0b push_x=%0d push_z=%0d",
                         $time, hit, push_x, push_z);
                err_count++;
            end
            else
            begin
                if (hit !== pending_push[0].hit)
                begin
                    $display("%0t hit expected %0b actual %0b",
                             $time, pending_push[0].hit, hit);
                    err_count++;
                end
                if (push_x !== pending_push[0].px)
                begin
                    $display("%0t push_x expected %0d actual %0d",
                             $time, pending_push[0].px, push_x);
                    err_count++;
                end
                if (push_z !== pending_push[0].pz)
                begin
                    $display("%0t push_z expected %0d actual %0d",
                             $time, pending_push[0].pz, push_z);
                    err_count++;
                end
                void'(pending_push.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycle_count > CycleLimit)
        begin
            $display("tb_circle_rect_pushout_top: errors");
            $finish;
        end
    end

    initial
    begin
        send_idle_pct = 25;
        recv_idle_pct = 75;
        rst_n = 1'b0;
        in_valid = 1'b0;
        corner_a_x = 0;
        corner_a_z = 0;
        corner_b_x = 0;
        corner_b_z = 0;
        center_x = 0;
        center_z = 0;
        radius = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(500);
        send_idle_pct = 75;
        recv_idle_pct = 25;
        test_random(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(530);
        repeat (100) @(posedge clk);
        if (err_count == 0)
            $display("tb_circle_rect_pushout_top: clean");
        else
            $display("tb_circle_rect_pushout_top: errors");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/crp_pkg.sv
rtl/circle_rect_pushout_top.sv
rtl/crp_checker.sv
tb/tb_circle_rect_pushout_top.sv
